### rtl/core/kt_pkg.sv
package kt_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_LOOKUP = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_RESP
  } state_t;

  localparam int KeyW     = 32;
  localparam int PayloadW = 64;
  localparam int EntryW   = KeyW + PayloadW;
  localparam int OccW     = 7;
  localparam int CapW     = 7;
  localparam logic [CapW-1:0] CapReset = 7'd64;

endpackage

### rtl/core/kt_ifs.sv
interface kt_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] key;
  logic signed [31:0] new_key;
  logic [63:0]        payload;

  modport source (output valid, cmd, key, new_key, payload, input ready);
  modport sink (input valid, cmd, key, new_key, payload, output ready);
endinterface

interface kt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] found_payload;
  logic [6:0]  occupancy;

  modport source (output valid, status, found_payload, occupancy, input ready);
  modport sink (input valid, status, found_payload, occupancy, output ready);
endinterface

### rtl/core/keyed_table_insert_delete_lookup_core.sv
// Sequence: a command scans the stored entries with one RAM read per entry, each
//   read compared against the key and the new key, then decides and responds; a
//   delete of a found entry also shifts every later entry down by one place first.
// Throughput: one command at a time; ready returns the cycle after the result
//   transfer.
// Reset: rst clears the sequencer and entry count and sets capacity to 64; RAM not cleared.
module keyed_table_insert_delete_lookup_core #(
  parameter int DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [kt_pkg::CapW-1:0] cfg_wdata,
  kt_req_if.sink                 req,
  kt_rsp_if.source               rsp
);
  import kt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > CapW) ? CW : CapW;

  state_t              state, state_next;
  cmd_t                cmd_q;
  logic [KeyW-1:0]     key_q, nkey_q;
  logic [PayloadW-1:0] pl_q;
  logic [CW-1:0]       idx, idx_next;
  logic                rd_pend, rd_pend_next;
  logic [AW-1:0]       rd_pos, rd_pos_next;
  logic                hit_k, hit_k_next, hit_nk, hit_nk_next;
  logic [AW-1:0]       hit_pos, hit_pos_next;
  logic [PayloadW-1:0] hit_pl, hit_pl_next;
  logic [CW-1:0]       count, count_next;
  logic [CapW-1:0]     capacity;
  status_t             status_q, status_next;
  logic [PayloadW-1:0] found_q, found_next;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [EntryW-1:0]   ram_wdata, ram_rdata;
  logic [KeyW-1:0]     rd_key;
  logic [EW-1:0]       cap_eff;
  logic                full, scan_done, req_xfer;

  assign rd_key    = ram_rdata[EntryW-1:PayloadW];
  assign cap_eff   = (EW'(capacity) > EW'(DEPTH)) ? EW'(DEPTH) : EW'(capacity);
  assign full      = EW'(count) >= cap_eff;
  assign scan_done = (idx >= count) && !rd_pend;
  assign req_xfer  = req.valid && req.ready;

  kt_ram #(.WIDTH(EntryW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (req_xfer) state_next = S_SCAN;
      S_SCAN:   if (scan_done) state_next = S_DECIDE;
      S_DECIDE: state_next = (cmd_q == CMD_DELETE && hit_k) ? S_SHIFT : S_RESP;
      S_SHIFT:  if (scan_done) state_next = S_RESP;
      S_RESP:   if (rsp.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready         = (state == S_IDLE);
    rsp.valid         = (state == S_RESP);
    rsp.status        = status_q;
    rsp.found_payload = found_q;
    rsp.occupancy     = OccW'(count);
  end

  always_comb begin
    idx_next     = idx;
    rd_pend_next = 1'b0;
    rd_pos_next  = rd_pos;
    hit_k_next   = hit_k;
    hit_nk_next  = hit_nk;
    hit_pos_next = hit_pos;
    hit_pl_next  = hit_pl;
    count_next   = count;
    status_next  = status_q;
    found_next   = found_q;
    ram_we       = 1'b0;
    ram_waddr    = count[AW-1:0];
    ram_wdata    = {key_q, pl_q};
    case (state)
      S_IDLE: begin
        idx_next    = '0;
        hit_k_next  = 1'b0;
        hit_nk_next = 1'b0;
      end
      S_SCAN, S_SHIFT: begin
        if (idx < count) begin
          idx_next     = idx + CW'(1);
          rd_pend_next = 1'b1;
          rd_pos_next  = idx[AW-1:0];
        end
        if (state == S_SCAN) begin
          if (rd_pend && rd_key == key_q && !hit_k) begin
            hit_k_next   = 1'b1;
            hit_pos_next = rd_pos;
            hit_pl_next  = ram_rdata[PayloadW-1:0];
          end
          if (rd_pend && rd_key == nkey_q) begin
            hit_nk_next = 1'b1;
          end
        end else begin
          if (rd_pend) begin
            ram_we    = 1'b1;
            ram_waddr = rd_pos - AW'(1);
            ram_wdata = ram_rdata;
          end
          if (scan_done) begin
            count_next = count - CW'(1);
          end
        end
      end
      S_DECIDE: begin
        found_next  = '0;
        status_next = ST_OK;
        case (cmd_q)
          CMD_INSERT: begin
            if (full) begin
              status_next = ST_FULL;
            end else if (hit_k) begin
              status_next = ST_DUPLICATE;
            end else begin
              ram_we     = 1'b1;
              count_next = count + CW'(1);
            end
          end
          CMD_DELETE: begin
            if (!hit_k) begin
              status_next = ST_NOT_FOUND;
            end else begin
              idx_next = CW'(hit_pos) + CW'(1);
            end
          end
          CMD_UPDATE: begin
            if (!hit_k) begin
              status_next = ST_NOT_FOUND;
            end else if (hit_nk) begin
              status_next = ST_DUPLICATE;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = hit_pos;
              ram_wdata = {nkey_q, pl_q};
            end
          end
          CMD_LOOKUP: begin
            if (hit_k) begin
              found_next = hit_pl;
            end else begin
              status_next = ST_NOT_FOUND;
            end
          end
          default: status_next = ST_NOT_FOUND;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      capacity <= CapReset;
      rd_pend  <= 1'b0;
      hit_k    <= 1'b0;
      hit_nk   <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      rd_pend <= rd_pend_next;
      hit_k   <= hit_k_next;
      hit_nk  <= hit_nk_next;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      cmd_q  <= cmd_t'(req.cmd);
      key_q  <= req.key;
      nkey_q <= req.new_key;
      pl_q   <= req.payload;
    end
    idx      <= idx_next;
    rd_pos   <= rd_pos_next;
    hit_pos  <= hit_pos_next;
    hit_pl   <= hit_pl_next;
    status_q <= status_next;
    found_q  <= found_next;
  end

endmodule

### rtl/core/kt_ram.sv
module kt_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/kt_chk.sv
module kt_chk (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  rsp_status,
  input logic [63:0] rsp_found_payload,
  input logic [6:0]  rsp_occupancy
);
  import kt_pkg::*;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(req_ready && rsp_valid))
    else $error("request ready while a result is pending");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready did not drop after a request transfer");

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_OK |-> rsp_found_payload == 64'd0)
    else $error("found_payload nonzero on a failed command");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_found_payload) && $stable(rsp_occupancy))
    else $error("stalled result changed");

endmodule

bind keyed_table_insert_delete_lookup_core kt_chk u_kt_chk (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_found_payload (rsp.found_payload),
  .rsp_occupancy     (rsp.occupancy)
);

### test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kt_pkg::*;

  localparam int TblDepth = 64;
  localparam int PoolSize = 72;
  localparam int PhaseItems = 234;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] key;
    logic [31:0] new_key;
    logic [63:0] payload;
  } table_req_t;

  typedef struct {
    status_t     status;
    logic [63:0] found;
    logic [6:0]  occ;
  } table_rsp_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           cfg_we = 1'b0;
  logic [CapW-1:0] cfg_wdata = '0;

  kt_req_if req_ch ();
  kt_rsp_if rsp_ch ();

  keyed_table_insert_delete_lookup_core #(
    .DEPTH(TblDepth)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_ch.sink),
    .rsp      (rsp_ch.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow table
  logic [31:0]     tbl_key [TblDepth];
  logic [63:0]     tbl_pay [TblDepth];
  int              tbl_count;
  logic [CapW-1:0] cap_reg;

  table_req_t pending_reqs[$];
  table_rsp_t expected_rsps[$];
  logic [31:0] key_pool [PoolSize];
  int  send_idle_pct = 0;
  int  rsp_stall_pct = 0;
  int  n_err = 0;
  logic req_fire = 1'b0;

  function automatic bit find_entry(logic [31:0] k, output int pos);
    pos = 0;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_key[i] == k) begin
        pos = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic table_rsp_t table_apply(table_req_t r);
    table_rsp_t res;
    int pos;
    int other;
    int lim;
    res.status = ST_OK;
    res.found = '0;
    lim = (cap_reg > TblDepth) ? TblDepth : int'(cap_reg);
    case (r.cmd)
      CMD_INSERT: begin
        if (tbl_count >= lim) begin
          res.status = ST_FULL;
        end else if (find_entry(r.key, other)) begin
          res.status = ST_DUPLICATE;
        end else begin
          tbl_key[tbl_count] = r.key;
          tbl_pay[tbl_count] = r.payload;
          tbl_count++;
        end
      end
      CMD_DELETE: begin
        if (!find_entry(r.key, pos)) begin
          res.status = ST_NOT_FOUND;
        end else begin
          for (int i = pos; i < tbl_count - 1; i++) begin
            tbl_key[i] = tbl_key[i+1];
            tbl_pay[i] = tbl_pay[i+1];
          end
          tbl_count--;
        end
      end
      CMD_UPDATE: begin
        if (!find_entry(r.key, pos)) begin
          res.status = ST_NOT_FOUND;
        end else if (find_entry(r.new_key, other)) begin
          res.status = ST_DUPLICATE;
        end else begin
          tbl_key[pos] = r.new_key;
          tbl_pay[pos] = r.payload;
        end
      end
      default: begin
        if (find_entry(r.key, pos)) begin
          res.found = tbl_pay[pos];
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
    endcase
    res.occ = tbl_count[6:0];
    return res;
  endfunction

  // request driver and response back-pressure
  always @(negedge clk) begin : drive_req
    table_req_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (!req_ch.valid || req_fire) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          req_ch.cmd     <= nxt.cmd;
          req_ch.key     <= nxt.key;
          req_ch.new_key <= nxt.new_key;
          req_ch.payload <= nxt.payload;
          req_ch.valid   <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // predict on request transfer, check on response transfer
  always @(posedge clk) begin : watch
    table_req_t got;
    table_rsp_t want;
    if (rst) begin
      req_fire <= 1'b0;
      tbl_count = 0;
      cap_reg = CapReset;
    end else begin
      req_fire <= req_ch.valid && req_ch.ready;
      if (cfg_we) cap_reg = cfg_wdata;
      if (req_ch.valid && req_ch.ready) begin
        got.cmd     = cmd_t'(req_ch.cmd);
        got.key     = req_ch.key;
        got.new_key = req_ch.new_key;
        got.payload = req_ch.payload;
        expected_rsps.push_back(table_apply(got));
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          n_err++;
          $display("%0t: unexpected response status %0d payload %h occ %0d", $realtime,
                   rsp_ch.status, rsp_ch.found_payload, rsp_ch.occupancy);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_ch.status !== want.status) begin
            n_err++;
            $display("%0t: status expected %0d got %0d", $realtime, want.status,
                     rsp_ch.status);
          end
          if (rsp_ch.found_payload !== want.found) begin
            n_err++;
            $display("%0t: found_payload expected %h got %h", $realtime, want.found,
                     rsp_ch.found_payload);
          end
          if (rsp_ch.occupancy !== want.occ) begin
            n_err++;
            $display("%0t: occupancy expected %0d got %0d", $realtime, want.occ,
                     rsp_ch.occupancy);
          end
        end
      end
    end
  end

  task automatic push_req(cmd_t c, logic [31:0] k, logic [31:0] nk, logic [63:0] p);
    table_req_t r;
    r.cmd = c;
    r.key = k;
    r.new_key = nk;
    r.payload = p;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [31:0] pick_key(int span);
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(span - 1)];
    return $urandom;
  endfunction

  task automatic queue_random(int n, int span);
    int r;
    cmd_t c;
    logic [31:0] k;
    logic [31:0] nk;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 60) c = CMD_INSERT;
      else if (r < 70) c = CMD_DELETE;
      else if (r < 85) c = CMD_UPDATE;
      else c = CMD_LOOKUP;
      k = pick_key(span);
      nk = ($urandom_range(9) == 0) ? k : pick_key(span);
      push_req(c, k, nk, {$urandom, $urandom});
    end
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CapW-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idle(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
      1: begin send_idle_pct = 78; rsp_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  rsp_stall_pct = 78; end
      default: begin send_idle_pct = 26; rsp_stall_pct = 26; end
    endcase
  endtask

  initial begin : stimulus
    int phase_cap [8];
    int eff;
    int span;
    phase_cap = '{64, 1, 127, 0, 8, 65, 33, 64};
    req_ch.valid = 1'b0;
    req_ch.cmd = '0;
    req_ch.key = '0;
    req_ch.new_key = '0;
    req_ch.payload = '0;
    rsp_ch.ready = 1'b0;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < PoolSize; i++) key_pool[i] = $urandom;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty table, extremes, duplicates, shifts
    push_req(CMD_LOOKUP, 32'h0, 32'h0, '0);
    push_req(CMD_DELETE, 32'h0, 32'h0, '0);
    push_req(CMD_UPDATE, 32'h0, 32'h1, 64'h1);
    push_req(CMD_INSERT, 32'h8000_0000, 32'h0, 64'h0);
    push_req(CMD_INSERT, 32'h7fff_ffff, 32'h0, '1);
    push_req(CMD_INSERT, 32'h0, 32'hffff_ffff, 64'h0123_4567_89ab_cdef);
    push_req(CMD_INSERT, 32'hffff_ffff, 32'h0, 64'ha5a5_a5a5_a5a5_a5a5);
    push_req(CMD_INSERT, 32'h0, 32'h0, 64'h1);
    push_req(CMD_LOOKUP, 32'h7fff_ffff, 32'h0, '0);
    push_req(CMD_LOOKUP, 32'hffff_ffff, 32'h0, '0);
    push_req(CMD_UPDATE, 32'h0, 32'h0, 64'h2);
    push_req(CMD_UPDATE, 32'h0, 32'h7fff_ffff, 64'h3);
    push_req(CMD_UPDATE, 32'h0001_2345, 32'h1, 64'h4);
    push_req(CMD_UPDATE, 32'h0, 32'h5, 64'h5a5a_5a5a_5a5a_5a5a);
    push_req(CMD_DELETE, 32'h8000_0000, 32'h0, '0);
    push_req(CMD_LOOKUP, 32'h5, 32'h0, '0);
    push_req(CMD_DELETE, 32'hffff_ffff, 32'h0, '0);
    push_req(CMD_LOOKUP, 32'hffff_ffff, 32'h0, '0);
    push_req(CMD_LOOKUP, 32'h8000_0000, 32'h0, '0);
    wait_idle();

    // capacity at and below occupancy; full wins over duplicate
    write_capacity(7'd2);
    write_capacity(7'd1);
    push_req(CMD_INSERT, 32'h5, 32'h0, 64'h6);
    push_req(CMD_INSERT, 32'h77, 32'h0, 64'h7);
    push_req(CMD_DELETE, 32'h5, 32'h0, '0);
    push_req(CMD_INSERT, 32'h77, 32'h0, 64'h8);
    push_req(CMD_DELETE, 32'h7fff_ffff, 32'h0, '0);
    push_req(CMD_INSERT, 32'h77, 32'h0, 64'h9);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      write_capacity(phase_cap[ph][6:0]);
      set_idle(ph % 4);
      eff = (phase_cap[ph] > TblDepth) ? TblDepth : phase_cap[ph];
      span = eff * 2 + 4;
      if (span > PoolSize) span = PoolSize;
      queue_random(PhaseItems, span);
      wait_idle();
    end

    repeat (150) @(posedge clk);
    if (n_err == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
